>>> sv/uf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf_pkg
// Types and constants shared by the union-find engine modules.
// ----------------------------------------------------------------------------
package uf_pkg;

  localparam int NODE_W = 10;
  localparam int SIZE_W = 11;
  localparam int RANK_W = 4;
  localparam int CNT_W  = 11;
  localparam int CFG_W  = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [RANK_W-1:0] RANK_MAX = 4'd15;
  localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd2047;
  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 11'd1024;

  localparam logic CMD_UNION = 1'b0;
  localparam logic CMD_FIND  = 1'b1;

  localparam logic MODE_SIZE = 1'b0;
  localparam logic MODE_RANK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNION_MODE = 1'd1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_BAD = 1'b1;

  typedef struct packed {
    logic              command;
    logic [NODE_W-1:0] node_a;
    logic [NODE_W-1:0] node_b;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] root;
    logic [SIZE_W-1:0] comp_size;
    logic              merged;
    logic [SIZE_W-1:0] largest_size;
    logic              status;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_COMP,
    ST_SZX,
    ST_SZY,
    ST_MERGE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr;
    logic ld_item;
    logic walk;
    logic comp;
    logic start_b;
    logic rd_x;
    logic rd_y;
    logic lat_x;
    logic lat_y;
    logic merge;
    logic out_ld;
    logic ph_b;
  } dp_cmd_t;

  typedef struct packed {
    logic bad_in;
    logic found;
    logic comp_end;
    logic x_eq_y;
    logic is_find;
    logic clr_done;
    logic out_free;
  } dp_sts_t;

endpackage

>>> sv/uf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module uf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/uf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf_ctrl
// Sequencer: clear pass, root walk, path compression, union merge, result.
// ----------------------------------------------------------------------------
module uf_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  uf_pkg::dp_sts_t sts,
  output uf_pkg::dp_cmd_t cmd
);

  import uf_pkg::*;

  state_t state_r, state_nxt;
  logic   ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    cmd       = '0;
    cmd.ph_b  = ph_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.ld_item = 1'b1;
          ph_nxt      = 1'b0;
          state_nxt   = sts.bad_in ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.found) begin
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        if (!sts.comp_end) begin
          cmd.comp = 1'b1;
        end else if (!ph_r && !sts.is_find) begin
          cmd.start_b = 1'b1;
          ph_nxt      = 1'b1;
          state_nxt   = ST_WALK;
        end else begin
          cmd.rd_x  = 1'b1;
          state_nxt = ST_SZX;
        end
      end
      ST_SZX: begin
        cmd.lat_x = 1'b1;
        if (sts.is_find || sts.x_eq_y) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.rd_y  = 1'b1;
          state_nxt = ST_SZY;
        end
      end
      ST_SZY: begin
        cmd.lat_y = 1'b1;
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        cmd.merge = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_ld = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

>>> sv/uf_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf_dpath
// Node tables, configuration registers, walk and merge logic, result register.
// ----------------------------------------------------------------------------
module uf_dpath #(
  parameter int NODES = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [uf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uf_pkg::CFG_W-1:0]         cfg_wdata,
  input  uf_pkg::in_item_t                 in_data,
  input  uf_pkg::dp_cmd_t                  cmd,
  output uf_pkg::dp_sts_t                  sts,
  input  logic                             out_ready,
  output logic                             out_valid,
  output uf_pkg::out_item_t                out_data
);

  import uf_pkg::*;

  localparam int AW = $clog2(NODES);
  localparam logic [16:0] NODES_L = 17'(NODES);
  localparam logic [AW-1:0] LAST_NODE = AW'(NODES - 1);

  logic [CNT_W-1:0]  node_count_r;
  logic              union_mode_r;

  logic              cmd_r;
  logic [AW-1:0]     a_r, b_r, cur_r, x_r, y_r, win_r;
  logic              bad_r, merged_r;
  logic [SIZE_W-1:0] sx_r, sy_r, s_r, largest_r;
  logic [RANK_W-1:0] rx_r, ry_r;
  logic [AW-1:0]     clr_cnt_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic [31:0]       in_a_ext, in_b_ext, root_ext;
  logic [AW-1:0]     in_a_addr, in_b_addr;
  logic              a_bad, b_bad;

  logic [AW-1:0]     par_rd, raddr, root_cur, start;
  logic [SIZE_W-1:0] sz_rd;
  logic [RANK_W-1:0] rk_rd;

  logic              win_x, tie;
  logic [AW-1:0]     win, lose;
  logic [SIZE_W:0]   sum;
  logic [SIZE_W-1:0] s_sat;

  logic              par_we, sz_we, rk_we;
  logic [AW-1:0]     par_waddr, sz_waddr, rk_waddr, par_wdata;
  logic [SIZE_W-1:0] sz_wdata;
  logic [RANK_W-1:0] rk_wdata;

  // range check on the incoming item
  assign in_a_ext  = 32'(in_data.node_a);
  assign in_b_ext  = 32'(in_data.node_b);
  assign in_a_addr = in_a_ext[AW-1:0];
  assign in_b_addr = in_b_ext[AW-1:0];
  assign a_bad = ({1'b0, in_data.node_a} >= node_count_r) ||
                 (17'(in_data.node_a) >= NODES_L);
  assign b_bad = ({1'b0, in_data.node_b} >= node_count_r) ||
                 (17'(in_data.node_b) >= NODES_L);

  assign root_cur = cmd.ph_b ? y_r : x_r;
  assign start    = cmd.ph_b ? b_r : a_r;

  assign sts.bad_in   = a_bad || ((in_data.command == CMD_UNION) && b_bad);
  assign sts.found    = (par_rd == cur_r);
  assign sts.comp_end = (cur_r == root_cur);
  assign sts.x_eq_y   = (x_r == y_r);
  assign sts.is_find  = (cmd_r == CMD_FIND);
  assign sts.clr_done = (clr_cnt_r == LAST_NODE);
  assign sts.out_free = !out_valid_r || out_ready;

  always_comb begin
    raddr = cur_r;
    if (cmd.ld_item) begin
      raddr = in_a_addr;
    end else if (cmd.walk) begin
      raddr = sts.found ? start : par_rd;
    end else if (cmd.comp) begin
      raddr = par_rd;
    end else if (cmd.start_b) begin
      raddr = b_r;
    end else if (cmd.rd_x) begin
      raddr = x_r;
    end else if (cmd.rd_y) begin
      raddr = y_r;
    end
  end

  // merge decision
  always_comb begin
    if (union_mode_r == MODE_RANK) begin
      win_x = (rx_r > ry_r);
      tie   = (rx_r == ry_r);
    end else begin
      win_x = (sx_r > sy_r);
      tie   = 1'b0;
    end
    win   = win_x ? x_r : y_r;
    lose  = win_x ? y_r : x_r;
    sum   = {1'b0, sx_r} + {1'b0, sy_r};
    s_sat = sum[SIZE_W] ? SIZE_MAX : sum[SIZE_W-1:0];
  end

  // table write ports
  always_comb begin
    par_we    = cmd.clr || cmd.comp || cmd.merge;
    par_waddr = cmd.clr ? clr_cnt_r : (cmd.comp ? cur_r : lose);
    par_wdata = cmd.clr ? clr_cnt_r : (cmd.comp ? root_cur : win);
    sz_we     = cmd.clr || cmd.merge;
    sz_waddr  = cmd.clr ? clr_cnt_r : win;
    sz_wdata  = cmd.clr ? SIZE_W'(1) : s_sat;
    rk_we     = cmd.clr || (cmd.merge && tie);
    rk_waddr  = cmd.clr ? clr_cnt_r : y_r;
    rk_wdata  = cmd.clr ? '0 : ((ry_r == RANK_MAX) ? RANK_MAX : ry_r + RANK_W'(1));
  end

  uf_ram #(.WIDTH(AW), .DEPTH(NODES)) u_parent (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (raddr),
    .rdata (par_rd)
  );

  uf_ram #(.WIDTH(SIZE_W), .DEPTH(NODES)) u_size (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (raddr),
    .rdata (sz_rd)
  );

  uf_ram #(.WIDTH(RANK_W), .DEPTH(NODES)) u_rank (
    .clk   (clk),
    .we    (rk_we),
    .waddr (rk_waddr),
    .wdata (rk_wdata),
    .raddr (raddr),
    .rdata (rk_rd)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= NODE_COUNT_RST;
      union_mode_r <= MODE_SIZE;
      largest_r    <= SIZE_W'(1);
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count_r <= cfg_wdata[CNT_W-1:0];
          REG_UNION_MODE: union_mode_r <= cfg_wdata[0];
          default: ;
        endcase
      end
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.merge && (s_sat > largest_r)) begin
        largest_r <= s_sat;
      end
      if (cmd.out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  assign root_ext = 32'(merged_r ? win_r : x_r);

  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      cmd_r    <= in_data.command;
      a_r      <= in_a_addr;
      b_r      <= in_b_addr;
      bad_r    <= sts.bad_in;
      merged_r <= 1'b0;
    end else if (cmd.merge) begin
      merged_r <= 1'b1;
    end
    if (cmd.ld_item) begin
      cur_r <= in_a_addr;
    end else if (cmd.walk) begin
      cur_r <= sts.found ? start : par_rd;
    end else if (cmd.comp) begin
      cur_r <= par_rd;
    end else if (cmd.start_b) begin
      cur_r <= b_r;
    end
    if (cmd.walk && sts.found) begin
      if (cmd.ph_b) begin
        y_r <= cur_r;
      end else begin
        x_r <= cur_r;
      end
    end
    if (cmd.lat_x) begin
      sx_r <= sz_rd;
      rx_r <= rk_rd;
    end
    if (cmd.lat_y) begin
      sy_r <= sz_rd;
      ry_r <= rk_rd;
    end
    if (cmd.merge) begin
      win_r <= win;
      s_r   <= s_sat;
    end
    if (cmd.out_ld) begin
      if (bad_r) begin
        out_data_r.root      <= '0;
        out_data_r.comp_size <= '0;
        out_data_r.merged    <= 1'b0;
        out_data_r.status    <= STATUS_BAD;
      end else begin
        out_data_r.root      <= root_ext[NODE_W-1:0];
        out_data_r.comp_size <= merged_r ? s_r : sx_r;
        out_data_r.merged    <= merged_r;
        out_data_r.status    <= STATUS_OK;
      end
      out_data_r.largest_size <= largest_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> sv/union_find_engine.sv
`timescale 1ns / 1ps
// Flow: a find walks to the root, then compresses the path; a union does the same for
//   both nodes, then reads the root sizes and ranks and merges unless they share a root.
// Throughput: one item at a time; the parent-table read port walks one link per cycle.
// Out-of-range items go straight to the result with no table walk or write.
// Reset: synchronous, active low; a clearing pass then rewrites every table entry,
//   with in_ready low; configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// union_find_engine
// Disjoint-set engine with path compression and union by size or rank.
// ----------------------------------------------------------------------------
module union_find_engine #(
  parameter int NODES = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [uf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [uf_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  uf_pkg::in_item_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output uf_pkg::out_item_t            out_data
);

  import uf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  uf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  uf_dpath #(.NODES(NODES)) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

>>> sv/uf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uf_checker
// Port-level checks for the union-find engine.
// ----------------------------------------------------------------------------
module uf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input uf_pkg::out_item_t out_data
);

  import uf_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid && !in_ready)
    else $error("outputs active right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_BAD) |->
      (out_data.root == '0) && (out_data.comp_size == '0) && !out_data.merged)
    else $error("rejected item carries data");

  a_size_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_OK) |->
      (out_data.comp_size != '0) && (out_data.largest_size >= out_data.comp_size))
    else $error("component size exceeds largest size");

  a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.merged |->
      (out_data.status == STATUS_OK) && (out_data.comp_size >= SIZE_W'(2)))
    else $error("merge reported with too small a component");

endmodule

bind union_find_engine uf_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/union_find_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_engine_test
// Self-checking bench for the union-find engine. A behavioral copy of the
// disjoint-set tables (parent, rank, size, largest component) predicts the
// report for every accepted command. Directed tests cover fresh finds, both
// union rules and the range checks. Random phases then run union/find mixes
// over node windows under both rules and several node counts, with random
// idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module union_find_engine_test;
  import uf_pkg::*;

  localparam int NODE_TOTAL      = 1024;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PRINT_CAP       = 100;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  in_item_t          in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_item_t         out_data;

  // behavioral disjoint-set state
  logic [NODE_W-1:0] parent_of [NODE_TOTAL];
  logic [RANK_W-1:0] rank_of   [NODE_TOTAL];
  logic [SIZE_W-1:0] size_of   [NODE_TOTAL];
  logic [SIZE_W-1:0] largest_comp;
  logic [CNT_W-1:0]  cfg_node_count;
  logic              cfg_union_mode;

  out_item_t root_reports_q[$];
  int        error_count   = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      holding       = 1'b0;
  event      hold_off_go;

  union_find_engine #(.NODES(NODE_TOTAL)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  task automatic report_error(input string msg);
    if (error_count < PRINT_CAP) begin
      $display("%0t ERROR %s", $time, msg);
    end
    error_count++;
  endtask

  function automatic void clear_sets();
    for (int i = 0; i < NODE_TOTAL; i++) begin
      parent_of[i] = NODE_W'(i);
      rank_of[i]   = '0;
      size_of[i]   = SIZE_W'(1);
    end
    largest_comp   = SIZE_W'(1);
    cfg_node_count = NODE_COUNT_RST;
    cfg_union_mode = MODE_SIZE;
  endfunction

  function automatic logic [NODE_W-1:0] root_of(input logic [NODE_W-1:0] n);
    logic [NODE_W-1:0] r;
    logic [NODE_W-1:0] nxt;
    r = n;
    while (parent_of[r] != r) begin
      r = parent_of[r];
    end
    while (n != r) begin
      nxt          = parent_of[n];
      parent_of[n] = r;
      n            = nxt;
    end
    return r;
  endfunction

  function automatic void apply_set_op(input in_item_t it);
    out_item_t         rep;
    logic [CNT_W-1:0]  limit;
    logic [NODE_W-1:0] ra;
    logic [NODE_W-1:0] rb;
    logic [NODE_W-1:0] win;
    logic [NODE_W-1:0] lose;
    logic [SIZE_W:0]   total;
    limit = (cfg_node_count < CNT_W'(NODE_TOTAL)) ? cfg_node_count : CNT_W'(NODE_TOTAL);
    rep   = '0;
    if (({1'b0, it.node_a} >= limit) ||
        (it.command == CMD_UNION && {1'b0, it.node_b} >= limit)) begin
      rep.status       = STATUS_BAD;
      rep.largest_size = largest_comp;
    end else begin
      ra       = root_of(it.node_a);
      rep.root = ra;
      if (it.command == CMD_UNION) begin
        rb = root_of(it.node_b);
        if (ra != rb) begin
          if (cfg_union_mode == MODE_SIZE) begin
            win = (size_of[ra] > size_of[rb]) ? ra : rb;
          end else if (rank_of[ra] > rank_of[rb]) begin
            win = ra;
          end else begin
            win = rb;
            if (rank_of[ra] == rank_of[rb] && rank_of[rb] != RANK_MAX) begin
              rank_of[rb] = rank_of[rb] + RANK_W'(1);
            end
          end
          lose            = (win == ra) ? rb : ra;
          parent_of[lose] = win;
          total           = {1'b0, size_of[win]} + {1'b0, size_of[lose]};
          size_of[win]    = (total > {1'b0, SIZE_MAX}) ? SIZE_MAX : total[SIZE_W-1:0];
          if (size_of[win] > largest_comp) begin
            largest_comp = size_of[win];
          end
          rep.root   = win;
          rep.merged = 1'b1;
        end
      end
      rep.comp_size    = size_of[rep.root];
      rep.largest_size = largest_comp;
      rep.status       = STATUS_OK;
    end
    root_reports_q.push_back(rep);
  endfunction

  // compare each result transfer against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (root_reports_q.size() == 0) begin
        report_error($sformatf("unexpected result %h", out_data));
      end else begin
        want = root_reports_q.pop_front();
        if (out_data.root !== want.root)
          report_error($sformatf("root got %0d want %0d", out_data.root, want.root));
        if (out_data.comp_size !== want.comp_size)
          report_error($sformatf("comp_size got %0d want %0d",
                                 out_data.comp_size, want.comp_size));
        if (out_data.merged !== want.merged)
          report_error($sformatf("merged got %0b want %0b", out_data.merged, want.merged));
        if (out_data.largest_size !== want.largest_size)
          report_error($sformatf("largest_size got %0d want %0d",
                                 out_data.largest_size, want.largest_size));
        if (out_data.status !== want.status)
          report_error($sformatf("status got %0b want %0b", out_data.status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || holding) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    forever begin
      @(hold_off_go);
      holding <= 1'b1;
      repeat (HOLD_OFF_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  task automatic send_item(input in_item_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    apply_set_op(item);
  endtask

  task automatic send_op(input logic cmd, input int a, input int b);
    in_item_t it;
    it.command = cmd;
    it.node_a  = NODE_W'(a);
    it.node_b  = NODE_W'(b);
    send_item(it);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (root_reports_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_NODE_COUNT) begin
      cfg_node_count = val;
    end else begin
      cfg_union_mode = val[0];
    end
  endtask

  task automatic configure(input int count, input logic mode);
    wait_drain();
    write_reg(REG_NODE_COUNT, CFG_W'(count));
    write_reg(REG_UNION_MODE, CFG_W'(mode));
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  task automatic test_fresh_finds();
    send_op(CMD_FIND, 0, 0);
    send_op(CMD_FIND, 1023, 1023);
    send_op(CMD_FIND, 682, 341);
  endtask

  task automatic test_union_by_size();
    configure(1024, MODE_SIZE);
    send_op(CMD_UNION, 1, 2);
    send_op(CMD_UNION, 3, 2);
    send_op(CMD_UNION, 2, 4);
    send_op(CMD_UNION, 5, 6);
    send_op(CMD_UNION, 6, 2);
    send_op(CMD_UNION, 1, 3);
    send_op(CMD_FIND, 5, 0);
    send_op(CMD_UNION, 0, 0);
  endtask

  task automatic test_range_checks();
    configure(8, MODE_SIZE);
    send_op(CMD_UNION, 7, 8);
    send_op(CMD_UNION, 8, 0);
    send_op(CMD_FIND, 3, 1023);
    send_op(CMD_FIND, 8, 0);
    send_op(CMD_UNION, 7, 7);
    configure(0, MODE_SIZE);
    send_op(CMD_FIND, 0, 0);
    send_op(CMD_UNION, 0, 0);
    configure(1, MODE_RANK);
    send_op(CMD_UNION, 0, 0);
    send_op(CMD_FIND, 1, 0);
    configure(2047, MODE_SIZE);
    send_op(CMD_FIND, 1023, 1023);
    send_op(CMD_UNION, 1023, 0);
  endtask

  task automatic test_union_by_rank();
    configure(1024, MODE_RANK);
    send_op(CMD_UNION, 900, 901);
    send_op(CMD_UNION, 902, 903);
    send_op(CMD_UNION, 900, 903);
    send_op(CMD_UNION, 904, 903);
    send_op(CMD_UNION, 903, 905);
    send_op(CMD_FIND, 900, 0);
  endtask

  task automatic test_random(input int items, input logic mode, input int count,
                             input int base, input int span);
    in_item_t    it;
    logic [31:0] bits;
    configure(count, mode);
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(99) < 85) begin
        it.command = ($urandom_range(99) < 60) ? CMD_UNION : CMD_FIND;
        it.node_a  = NODE_W'(base + $urandom_range(span - 1));
        it.node_b  = NODE_W'(base + $urandom_range(span - 1));
      end else begin
        bits = $urandom;
        it   = bits[$bits(in_item_t)-1:0];
      end
      send_item(it);
    end
  endtask

  task automatic test_backpressure();
    wait_drain();
    -> hold_off_go;
    for (int i = 0; i < 30; i++) begin
      send_op(($urandom_range(1) != 0) ? CMD_FIND : CMD_UNION,
              $urandom_range(1023), $urandom_range(1023));
    end
    wait_drain();
  endtask

  initial begin
    clear_sets();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    set_idle(21, 64);
    test_fresh_finds();
    test_union_by_size();
    test_range_checks();
    test_union_by_rank();
    test_random(250, MODE_SIZE, 1024, 16, 48);
    test_random(250, MODE_RANK, 200, 128, 72);

    set_idle(64, 21);
    test_random(250, MODE_SIZE, 2047, 256, 256);
    test_random(250, MODE_RANK, 1000, 600, 400);

    set_idle(0, 0);
    test_random(250, MODE_SIZE, 1024, 960, 64);
    test_backpressure();
    test_random(250, MODE_RANK, 1024, 0, 1024);

    wait_drain();
    repeat (50) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
